>>> rtl/core/lzwvd_pkg.sv
// ----------------------------------------------------------------------------
// LZW variable width decoder package
// Shared constants, operation and table entry types for the decoder.
// ----------------------------------------------------------------------------
package lzwvd_pkg;

   localparam int TABLE_ENTRIES   = 4096;
   localparam int MAX_CODE_BITS   = 12;
   localparam int START_CODE_BITS = 9;

   localparam int BYTE_BITS   = 8;
   localparam int POS_BITS    = 16;
   localparam int LEN_BITS    = 12;
   localparam int INDEX_WIDTH = $clog2(TABLE_ENTRIES);
   localparam int NFC_BITS    = INDEX_WIDTH + 1;
   localparam int WIDE_BITS   =
      ((MAX_CODE_BITS > INDEX_WIDTH) ? MAX_CODE_BITS : INDEX_WIDTH) + 1;
   localparam int HOLDER_BITS = MAX_CODE_BITS + BYTE_BITS;
   localparam int COUNT_BITS  = $clog2(HOLDER_BITS + 1);
   localparam int WIDTH_BITS  = $clog2(MAX_CODE_BITS + 1);

   localparam logic [MAX_CODE_BITS-1:0] CODE_CLEAR      = MAX_CODE_BITS'(256);
   localparam logic [MAX_CODE_BITS-1:0] CODE_END        = MAX_CODE_BITS'(257);
   localparam logic [NFC_BITS-1:0]      CODE_FIRST_FREE = NFC_BITS'(258);

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_LITERAL  = 2'd0,
      KIND_COPY     = 2'd1,
      KIND_END      = 2'd2,
      KIND_OVERFLOW = 2'd3
   } result_kind_type;

   typedef enum logic [2:0] {
      OP_FIRST,
      OP_LITERAL,
      OP_COPY,
      OP_END,
      OP_OVERFLOW
   } op_kind_type;

   typedef struct packed {
      op_kind_type                kind;
      logic [MAX_CODE_BITS-1:0]   code;
      logic [INDEX_WIDTH-1:0]     free_code;
      logic                       append;
      logic                       restart;
   } op_type;

   typedef struct packed {
      logic [POS_BITS-1:0]  offset;
      logic [LEN_BITS-1:0]  length;
      logic [BYTE_BITS-1:0] first_byte;
   } entry_type;

endpackage

>>> rtl/core/lzw_variable_width_decoder.sv
// ----------------------------------------------------------------------------
// LZW variable width decoder
// Decodes 9 to 12 bit LZW codes into literal and copy commands.
// ----------------------------------------------------------------------------
// Each result is registered in the queue, then in s1, then at the output.
// Throughput: one byte per cycle unless stalled; first, literal and copy codes
// each take one table read and one write in the single back-end execute stage.
// Reset: synchronous; clears all control state. The string table is not
// cleared and needs no clearing pass; the decoder is ready right after reset.
module lzw_variable_width_decoder import lzwvd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_BITS-1:0] req_compressed_byte,
   input  logic                 req_block_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_result_kind,
   output logic [BYTE_BITS-1:0] rsp_byte_value,
   output logic [POS_BITS-1:0]  rsp_copy_offset,
   output logic [LEN_BITS-1:0]  rsp_copy_length,
   output logic                 rsp_append_byte,
   output logic [POS_BITS-1:0]  rsp_output_position
);

   logic   queue_full, push_valid, head_valid, pop;
   op_type push_op, head_op;

   lzwvd_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_compressed_byte (req_compressed_byte),
      .req_block_start     (req_block_start),
      .req_stall           (req_stall),
      .queue_full          (queue_full),
      .push_valid          (push_valid),
      .push_op             (push_op)
   );

   lzwvd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .queue_full (queue_full),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop)
   );

   lzwvd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_op             (head_op),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_copy_offset     (rsp_copy_offset),
      .rsp_copy_length     (rsp_copy_length),
      .rsp_append_byte     (rsp_append_byte),
      .rsp_output_position (rsp_output_position)
   );

endmodule

>>> rtl/core/lzwvd_front.sv
// ----------------------------------------------------------------------------
// LZW decoder front end
// Unpacks bytes into codes, tracks width, free code and halt, classifies.
// ----------------------------------------------------------------------------
module lzwvd_front import lzwvd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [BYTE_BITS-1:0] req_compressed_byte,
   input  logic                 req_block_start,
   output logic                 req_stall,
   input  logic                 queue_full,
   output logic                 push_valid,
   output op_type               push_op
);

   logic [HOLDER_BITS-1:0] holder_ff, holder_in, holder_cur, shifted, aligned;
   logic [COUNT_BITS-1:0]  bits_ff, bits_in, bits_cur, bits_sum, shift_amt;
   logic [WIDTH_BITS-1:0]  width_ff, width_in, width_cur;
   logic [NFC_BITS-1:0]    nfc_ff, nfc_in, nfc_cur, nfc_next;
   logic                   awaiting_ff, awaiting_in, awaiting_cur;
   logic                   halted_ff, halted_in, halted_cur;
   logic                   pending_ff, pending_in;
   logic                   accept;
   logic [MAX_CODE_BITS:0] code_mask;
   logic [MAX_CODE_BITS-1:0] code;
   logic [WIDE_BITS-1:0]   grow_mark;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      holder_cur   = holder_ff;
      bits_cur     = bits_ff;
      width_cur    = width_ff;
      nfc_cur      = nfc_ff;
      awaiting_cur = awaiting_ff;
      halted_cur   = halted_ff;
      if (req_block_start) begin
         holder_cur   = '0;
         bits_cur     = '0;
         width_cur    = WIDTH_BITS'(START_CODE_BITS);
         nfc_cur      = CODE_FIRST_FREE;
         awaiting_cur = 1'b1;
         halted_cur   = 1'b0;
      end

      holder_in   = holder_ff;
      bits_in     = bits_ff;
      width_in    = width_ff;
      nfc_in      = nfc_ff;
      awaiting_in = awaiting_ff;
      halted_in   = halted_ff;
      pending_in  = pending_ff;
      push_valid  = 1'b0;
      push_op     = '0;

      shifted   = {holder_cur[HOLDER_BITS-BYTE_BITS-1:0], req_compressed_byte};
      bits_sum  = bits_cur + COUNT_BITS'(BYTE_BITS);
      shift_amt = bits_sum - COUNT_BITS'(width_cur);
      aligned   = shifted >> shift_amt;
      code_mask = ({{MAX_CODE_BITS{1'b0}}, 1'b1} << width_cur) - 1'b1;
      code      = aligned[MAX_CODE_BITS-1:0] & code_mask[MAX_CODE_BITS-1:0];
      nfc_next  = nfc_cur + NFC_BITS'(1);
      grow_mark = (WIDE_BITS'(1) << width_cur) - WIDE_BITS'(1);

      push_op.code      = code;
      push_op.free_code = nfc_cur[INDEX_WIDTH-1:0];
      push_op.restart   = pending_ff || req_block_start;
      push_op.kind      = OP_END;

      if (accept) begin
         holder_in   = holder_cur;
         bits_in     = bits_cur;
         width_in    = width_cur;
         nfc_in      = nfc_cur;
         awaiting_in = awaiting_cur;
         halted_in   = halted_cur;
         if (req_block_start) begin
            pending_in = 1'b1;
         end
         if (!halted_cur) begin
            holder_in = shifted;
            bits_in   = bits_sum;
            if (bits_sum >= COUNT_BITS'(width_cur)) begin
               bits_in = shift_amt;
               priority if (code == CODE_END) begin
                  push_valid   = 1'b1;
                  push_op.kind = OP_END;
                  halted_in    = 1'b1;
               end else if (WIDE_BITS'(code) >= WIDE_BITS'(TABLE_ENTRIES)) begin
                  push_valid   = 1'b1;
                  push_op.kind = OP_OVERFLOW;
                  halted_in    = 1'b1;
               end else if (awaiting_cur) begin
                  push_valid   = 1'b1;
                  push_op.kind = OP_FIRST;
                  awaiting_in  = 1'b0;
               end else if (code == CODE_CLEAR) begin
                  awaiting_in = 1'b1;
                  nfc_in      = CODE_FIRST_FREE;
                  width_in    = WIDTH_BITS'(START_CODE_BITS);
               end else if (nfc_cur >= NFC_BITS'(TABLE_ENTRIES)) begin
                  push_valid   = 1'b1;
                  push_op.kind = OP_OVERFLOW;
                  halted_in    = 1'b1;
               end else begin
                  push_valid     = 1'b1;
                  push_op.kind   = (code < CODE_CLEAR) ? OP_LITERAL : OP_COPY;
                  push_op.append = WIDE_BITS'(code) >= WIDE_BITS'(nfc_cur);
                  nfc_in         = nfc_next;
                  if (WIDE_BITS'(nfc_next) == grow_mark &&
                      width_cur < WIDTH_BITS'(MAX_CODE_BITS)) begin
                     width_in = width_cur + WIDTH_BITS'(1);
                  end
               end
            end
         end
         if (push_valid) begin
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holder_ff   <= '0;
         bits_ff     <= '0;
         width_ff    <= WIDTH_BITS'(START_CODE_BITS);
         nfc_ff      <= CODE_FIRST_FREE;
         awaiting_ff <= 1'b1;
         halted_ff   <= 1'b0;
         pending_ff  <= 1'b0;
      end else begin
         holder_ff   <= holder_in;
         bits_ff     <= bits_in;
         width_ff    <= width_in;
         nfc_ff      <= nfc_in;
         awaiting_ff <= awaiting_in;
         halted_ff   <= halted_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

>>> rtl/core/lzwvd_queue.sv
// ----------------------------------------------------------------------------
// LZW decoder operation queue
// Short FIFO of classified operations between front end and back end.
// ----------------------------------------------------------------------------
module lzwvd_queue import lzwvd_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   input  op_type push_op,
   output logic   queue_full,
   output logic   head_valid,
   output op_type head_op,
   input  logic   pop
);

   op_type                    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign queue_full = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS + 1)'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - (QUEUE_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

>>> rtl/core/lzwvd_back.sv
// ----------------------------------------------------------------------------
// LZW decoder back end
// Reads the string table, builds commands, adds entries, drives results.
// ----------------------------------------------------------------------------
module lzwvd_back import lzwvd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  op_type               head_op,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_result_kind,
   output logic [BYTE_BITS-1:0] rsp_byte_value,
   output logic [POS_BITS-1:0]  rsp_copy_offset,
   output logic [LEN_BITS-1:0]  rsp_copy_length,
   output logic                 rsp_append_byte,
   output logic [POS_BITS-1:0]  rsp_output_position
);

   entry_type table_mem [TABLE_ENTRIES];

   logic                   s1_valid_ff, s1_valid_in;
   op_type                 s1_op_ff;
   entry_type              rd_ff;
   entry_type              shadow_ff, shadow_in;
   logic [BYTE_BITS-1:0]   cfb_ff, cfb_in;
   logic [POS_BITS-1:0]    wp_ff, wp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_kind_type        kind_ff, kind_in;
   logic [BYTE_BITS-1:0]   byte_ff, byte_in;
   logic [POS_BITS-1:0]    offset_ff, offset_in;
   logic [LEN_BITS-1:0]    length_ff, length_in;
   logic                   append_ff, append_in;

   logic                   rsp_free, s1_fire, bypass;
   logic [POS_BITS-1:0]    start;
   entry_type              src, new_entry;
   logic                   wr_en;
   logic [INDEX_WIDTH-1:0] wr_addr;
   entry_type              wr_data;
   logic [BYTE_BITS-1:0]   code_byte;

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire     = s1_valid_ff && rsp_free;
   assign pop         = head_valid && (!s1_valid_ff || s1_fire);
   assign s1_valid_in = pop || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);
   assign bypass      = s1_fire && wr_en &&
                        (wr_addr == head_op.code[INDEX_WIDTH-1:0]);

   always_comb begin
      start     = s1_op_ff.restart ? '0 : wp_ff;
      src       = s1_op_ff.append ? shadow_ff : rd_ff;
      code_byte = s1_op_ff.code[BYTE_BITS-1:0];
      new_entry.offset     = start - POS_BITS'(shadow_ff.length);
      new_entry.length     = shadow_ff.length + LEN_BITS'(1);
      new_entry.first_byte = shadow_ff.first_byte;

      wr_en     = 1'b0;
      wr_addr   = s1_op_ff.free_code;
      wr_data   = new_entry;
      shadow_in = shadow_ff;
      cfb_in    = cfb_ff;
      wp_in     = start;
      kind_in   = KIND_END;
      byte_in   = '0;
      offset_in = '0;
      length_in = '0;
      append_in = 1'b0;

      unique case (s1_op_ff.kind)
         OP_FIRST: begin
            kind_in   = KIND_LITERAL;
            byte_in   = code_byte;
            wp_in     = start + POS_BITS'(1);
            wr_en     = 1'b1;
            wr_addr   = s1_op_ff.code[INDEX_WIDTH-1:0];
            wr_data   = '{offset: start, length: LEN_BITS'(1), first_byte: code_byte};
            shadow_in = '{offset: start, length: LEN_BITS'(1), first_byte: code_byte};
            cfb_in    = code_byte;
         end
         OP_LITERAL: begin
            kind_in   = KIND_LITERAL;
            byte_in   = code_byte;
            wp_in     = start + POS_BITS'(1);
            wr_en     = 1'b1;
            shadow_in = '{offset: start, length: LEN_BITS'(1), first_byte: code_byte};
            cfb_in    = code_byte;
         end
         OP_COPY: begin
            kind_in   = KIND_COPY;
            byte_in   = s1_op_ff.append ? cfb_ff : '0;
            offset_in = src.offset;
            length_in = src.length;
            append_in = s1_op_ff.append;
            wp_in     = start + POS_BITS'(src.length) + POS_BITS'(s1_op_ff.append);
            wr_en     = 1'b1;
            shadow_in = (WIDE_BITS'(s1_op_ff.code) == WIDE_BITS'(s1_op_ff.free_code)) ?
                        new_entry : rd_ff;
            cfb_in    = src.first_byte;
         end
         OP_END: begin
            kind_in = KIND_END;
         end
         OP_OVERFLOW: begin
            kind_in = KIND_OVERFLOW;
         end
         default: begin
            kind_in = KIND_OVERFLOW;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            wp_ff <= wp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff <= head_op;
      end
      if (s1_fire) begin
         shadow_ff <= shadow_in;
         cfb_ff    <= cfb_in;
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         append_ff <= append_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (bypass) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= table_mem[head_op.code[INDEX_WIDTH-1:0]];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_byte_value      = byte_ff;
   assign rsp_copy_offset     = offset_ff;
   assign rsp_copy_length     = length_ff;
   assign rsp_append_byte     = append_ff;
   assign rsp_output_position = wp_ff;

endmodule

>>> rtl/core/lzwvd_checker.sv
// ----------------------------------------------------------------------------
// LZW decoder port checker
// Checks result channel behavior seen at the decoder's ports.
// ----------------------------------------------------------------------------
module lzwvd_checker import lzwvd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [1:0]           rsp_result_kind,
   input logic [BYTE_BITS-1:0] rsp_byte_value,
   input logic [POS_BITS-1:0]  rsp_copy_offset,
   input logic [LEN_BITS-1:0]  rsp_copy_length,
   input logic                 rsp_append_byte,
   input logic [POS_BITS-1:0]  rsp_output_position
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_copy_offset) && $stable(rsp_output_position))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_literal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_LITERAL |->
      rsp_copy_length == '0 && rsp_copy_offset == '0 && !rsp_append_byte)
      else $error("literal carries copy fields");

   a_stop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_END || rsp_result_kind == KIND_OVERFLOW) |->
      rsp_byte_value == '0 && rsp_copy_length == '0 && !rsp_append_byte)
      else $error("end or overflow carries command fields");

   a_append_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_append_byte |-> rsp_result_kind == KIND_COPY)
      else $error("append flag outside copy");

endmodule

bind lzw_variable_width_decoder lzwvd_checker u_lzwvd_checker (.*);
